// File: design/lwkd_pkg.sv
package lwkd_pkg;

    // Window buffer capacity and the widths that follow from it.
    localparam int MAX_LEN = 4096;
    localparam int PTR_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // Fixed field widths of the channels and the register.
    localparam int CHAR_W     = 8;
    localparam int NUM_BYTES  = 1 << CHAR_W;
    localparam int K_W        = 9;
    localparam int DIST_W     = 9;
    localparam int OUT_LEN_W  = 13;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [OUT_LEN_W-1:0] LEN_SAT = '1;
    localparam logic [K_W-1:0]       K_RESET = K_W'(2);

    localparam logic [APB_ADDR_W-1:0] ADDR_K_LIMIT = APB_ADDR_W'(0);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [CHAR_W-1:0] char_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP_RD,
        ST_DROP_CNT,
        ST_DROP_WR,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic store_rd;
        logic store_wr;
        logic cnt_rd;
        logic cnt_wr;
        logic cnt_inc;
        logic finish;
    } ctl_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        if (p == PTR_W'(MAX_LEN - 1)) begin
            return '0;
        end
        return p + ptr_t'(1);
    endfunction

    function automatic logic [OUT_LEN_W-1:0] sat_len(input len_t v);
        if (32'(v) > 32'(LEN_SAT)) begin
            return LEN_SAT;
        end
        return OUT_LEN_W'(v);
    endfunction

endpackage

// File: design/longest_window_k_distinct_core.sv
// Streams a byte string in, one byte per transfer with tlast on the final byte,
// and answers each byte with the longest window seen so far in this string that
// holds at most k_limit distinct byte values, plus the current window length and
// a sticky overflow flag once the 4096-byte window buffer has had to force out
// its oldest byte. A new byte is taken only once the last one is through: a
// forced drop on a full buffer comes first, then the push, then one drop per
// byte removed for distinctness, and the result waits for a free output. This
// follows from the single-port per-byte count table, which needs a read and a
// write for every byte entering or leaving the window. All string state clears
// right after the result of the final byte, with no clearing pass. k_limit may
// only be written while the block is idle.
module longest_window_k_distinct_core
    import lwkd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] char_in
    input  logic                  s_tlast,   // last_char
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [12:0] best_len, [25:13] window_len,
                                             // [26] overflow, [31:27] zero
    output logic                  m_tlast    // final_result
);

    state_t state_reg, state_next;
    ctl_t   ctl;

    logic [K_W-1:0]    k_limit_reg;
    char_t             char_reg, char_next;
    logic              last_reg, last_next;
    logic              pushed_reg, pushed_next;
    logic [DIST_W-1:0] distinct_reg, distinct_next;
    ptr_t              head_ptr_reg, head_ptr_next;
    ptr_t              tail_ptr_reg, tail_ptr_next;
    len_t              cur_len_reg, cur_len_next;
    len_t              best_reg, best_next;
    logic              ovf_reg, ovf_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    // Window buffer and per-byte count table.
    char_t                store_mem [MAX_LEN];
    char_t                store_rdata_reg;
    len_t                 cnt_mem [NUM_BYTES];
    len_t                 cnt_rdata_reg;
    logic                 cnt_rd_vld_reg;
    logic [NUM_BYTES-1:0] cnt_vld_reg;

    logic  accept;
    logic  evict;
    logic  out_free;
    logic  cfg_write;
    char_t cnt_addr;
    len_t  cnt_eff;
    len_t  cnt_upd;
    logic  cnt_wr_en;
    len_t  best_upd;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr)
            ADDR_K_LIMIT: prdata = APB_DATA_W'(k_limit_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_limit_reg <= K_RESET;
        end else if (cfg_write && paddr == ADDR_K_LIMIT) begin
            k_limit_reg <= pwdata[K_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign evict    = (distinct_reg > k_limit_reg) && (cur_len_reg != '0);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (cur_len_reg >= LEN_W'(MAX_LEN)) ? ST_DROP_RD : ST_PUSH_RD;
                end
            end
            ST_DROP_RD:  state_next = ST_DROP_CNT;
            ST_DROP_CNT: state_next = ST_DROP_WR;
            ST_DROP_WR:  state_next = pushed_reg ? ST_CHECK : ST_PUSH_RD;
            ST_PUSH_RD:  state_next = ST_PUSH_WR;
            ST_PUSH_WR:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (evict) begin
                    state_next = ST_DROP_RD;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_DROP_RD:  ctl.store_rd = 1'b1;
            ST_DROP_CNT: ctl.cnt_rd   = 1'b1;
            ST_DROP_WR:  ctl.cnt_wr   = 1'b1;
            ST_PUSH_RD: begin
                ctl.store_wr = 1'b1;
                ctl.cnt_rd   = 1'b1;
            end
            ST_PUSH_WR: begin
                ctl.cnt_wr  = 1'b1;
                ctl.cnt_inc = 1'b1;
            end
            ST_CHECK: ctl.finish = !evict && out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- memories ----------------
    // While a byte is being dropped the table is addressed by the byte read
    // back from the window buffer; otherwise by the incoming byte.
    assign cnt_addr = (state_reg == ST_DROP_CNT || state_reg == ST_DROP_WR)
                    ? store_rdata_reg : char_reg;

    always_ff @(posedge aclk) begin
        if (ctl.store_wr) begin
            store_mem[tail_ptr_reg] <= char_reg;
        end
        if (ctl.store_rd) begin
            store_rdata_reg <= store_mem[head_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_wr_en) begin
            cnt_mem[cnt_addr] <= cnt_upd;
        end
        if (ctl.cnt_rd) begin
            cnt_rdata_reg  <= cnt_mem[cnt_addr];
            cnt_rd_vld_reg <= cnt_vld_reg[cnt_addr];
        end
    end

    // An entry not written since the last string end counts as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
        end else if (ctl.finish && last_reg) begin
            cnt_vld_reg <= '0;
        end else if (cnt_wr_en) begin
            cnt_vld_reg[cnt_addr] <= 1'b1;
        end
    end

    // ---------------- datapath ----------------
    assign cnt_eff   = cnt_rd_vld_reg ? cnt_rdata_reg : '0;
    assign cnt_upd   = ctl.cnt_inc ? cnt_eff + len_t'(1) : cnt_eff - len_t'(1);
    assign cnt_wr_en = ctl.cnt_wr && (ctl.cnt_inc || cnt_eff != '0);
    assign best_upd  = (cur_len_reg > best_reg) ? cur_len_reg : best_reg;

    always_comb begin
        char_next     = char_reg;
        last_next     = last_reg;
        pushed_next   = pushed_reg;
        distinct_next = distinct_reg;
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        cur_len_next  = cur_len_reg;
        best_next     = best_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (accept) begin
            char_next   = s_tdata[CHAR_W-1:0];
            last_next   = s_tlast;
            pushed_next = 1'b0;
            if (cur_len_reg >= LEN_W'(MAX_LEN)) begin
                ovf_next = 1'b1;
            end
        end

        if (ctl.cnt_wr && !ctl.cnt_inc) begin
            if (cnt_eff == len_t'(1) && distinct_reg != '0) begin
                distinct_next = distinct_reg - DIST_W'(1);
            end
            head_ptr_next = ptr_inc(head_ptr_reg);
            cur_len_next  = cur_len_reg - len_t'(1);
        end

        if (ctl.cnt_wr && ctl.cnt_inc) begin
            if (cnt_eff == '0) begin
                distinct_next = distinct_reg + DIST_W'(1);
            end
            tail_ptr_next = ptr_inc(tail_ptr_reg);
            cur_len_next  = cur_len_reg + len_t'(1);
            pushed_next   = 1'b1;
        end

        if (ctl.finish) begin
            best_next     = best_upd;
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({ovf_reg, sat_len(cur_len_reg), sat_len(best_upd)});
            m_tlast_next  = last_reg;
            if (last_reg) begin
                distinct_next = '0;
                head_ptr_next = '0;
                tail_ptr_next = '0;
                cur_len_next  = '0;
                best_next     = '0;
                ovf_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pushed_reg   <= 1'b0;
            distinct_reg <= '0;
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            cur_len_reg  <= '0;
            best_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pushed_reg   <= pushed_next;
            distinct_reg <= distinct_next;
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            cur_len_reg  <= cur_len_next;
            best_reg     <= best_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg    <= char_next;
        last_reg    <= last_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
